// ===== rtl/tcpt_pkg.sv =====
// Shared types and constants for the TCP Tahoe window controller.
// No dependencies; every other file refers to it by scoped names.
package tcpt_pkg;

   localparam int SEQ_BITS_DEF  = 16;
   localparam int TIME_BITS_DEF = 32;
   localparam int CFG_BITS      = 16;
   localparam int GAIN_BITS     = 17;
   localparam int FRAC_BITS     = 16;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic [GAIN_BITS-1:0] GAIN_ONE = 17'h10000;

   localparam logic [CFG_BITS-1:0] RST_TOTAL_PACKETS  = 16'd1;
   localparam logic [CFG_BITS-1:0] RST_INITIAL_WINDOW = 16'd1;
   localparam logic [CFG_BITS-1:0] RST_RTT_GAIN       = 16'd8192;
   localparam logic [CFG_BITS-1:0] RST_WAIT_OFFSET    = 16'd10000;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_TOTAL_PACKETS  = 2'd0,
      CSR_INITIAL_WINDOW = 2'd1,
      CSR_RTT_GAIN       = 2'd2,
      CSR_WAIT_OFFSET    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_TIMEOUT = 2'd1,
      KIND_SYNACK  = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAGE_HANDSHAKE = 2'd0,
      STAGE_DATA      = 2'd1,
      STAGE_DONE      = 2'd2,
      STAGE_SPARE     = 2'd3
   } stage_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_AK,
      ST_MUL_RG,
      ST_MUL_DK,
      ST_MUL_EG,
      ST_WAIT,
      ST_DIV,
      ST_FINISH
   } fsm_type;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

// ===== rtl/tcpt_mac_unit.sv =====
// Shared bit-serial unit: shift-add multiply by a 17-bit gain, or
// restoring divide of a 17-bit dividend (2^16 from the top level) by an MW-bit divisor. Depends on tcpt_pkg.
module tcpt_mac_unit #(
   parameter int MW = tcpt_pkg::GAIN_BITS,
   localparam int AW = MW + tcpt_pkg::GAIN_BITS + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tcpt_pkg::unit_ctl_type          ctl,
   input  logic [MW-1:0]                   mcand,
   input  logic [tcpt_pkg::GAIN_BITS-1:0]  mplier,
   output tcpt_pkg::unit_sts_type          sts,
   output logic [AW-1:0]                   product,
   output logic [tcpt_pkg::GAIN_BITS-1:0]  quotient
);

   localparam int GB = tcpt_pkg::GAIN_BITS;
   localparam int CB = $clog2(GB);
   localparam logic [CB-1:0] LAST_STEP = CB'(GB - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CB-1:0]         cnt_ff, cnt_in;
   tcpt_pkg::unit_op_type op_ff;
   logic [MW-1:0]         mcand_ff;
   logic [GB-1:0]         mplier_ff, mplier_in;
   logic [AW-1:0]         acc_ff, acc_in;
   logic [AW-1:0]         shifted, addend;
   logic [AW:0]           sum;
   logic                  is_div;

   assign is_div  = (op_ff == tcpt_pkg::OP_DIV);
   assign shifted = {acc_ff[AW-2:0], is_div & mplier_ff[GB-1]};
   assign addend  = is_div ? ~AW'(mcand_ff) : (mplier_ff[GB-1] ? AW'(mcand_ff) : '0);
   assign sum     = {1'b0, shifted} + {1'b0, addend} + (AW+1)'(is_div);

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      if (ctl.start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         acc_in    = '0;
         mplier_in = mplier;
      end else if (busy_ff) begin
         // keep the difference only when it did not borrow
         if (is_div) begin
            acc_in    = sum[AW] ? sum[AW-1:0] : shifted;
            mplier_in = {mplier_ff[GB-2:0], sum[AW]};
         end else begin
            acc_in    = sum[AW-1:0];
            mplier_in = {mplier_ff[GB-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      if (ctl.start) begin
         op_ff    <= ctl.op;
         mcand_ff <= mcand;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign product  = acc_ff;
   assign quotient = mplier_ff;

endmodule

// ===== rtl/tcp_tahoe_window_control.sv =====
// Top level of the TCP Tahoe sender window controller for one flow.
// Depends on tcpt_pkg and tcpt_mac_unit.
//
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------------
//  req     | req_tvalid/tready/tdata/tuser  | one event request (ack, timeout, synack)
//  rsp     | rsp_tvalid/tready/tdata        | one result per request
//  csr     | csr_we/csr_index/csr_wdata     | register write, no wait, no read-back
//
// Steps: an accepted ack runs four 17-step multiplies on the shared serial unit and,
// in congestion avoidance unless it is the last packet or a fourth duplicate, one
// 17-step divide; a synack in the handshake passes through check, wait and finish,
// timeouts and ignored requests through check and finish. Reset is synchronous and
// clears all flow state at once. A result waits in the output register while the next
// request is taken; the finish step stalls only while that register is full and not taken.
module tcp_tahoe_window_control #(
   parameter int SEQ_BITS  = tcpt_pkg::SEQ_BITS_DEF,
   parameter int TIME_BITS = tcpt_pkg::TIME_BITS_DEF,
   localparam int IN_W  = ((SEQ_BITS + 2 * TIME_BITS + 7) / 8) * 8,
   localparam int OUT_W = ((2 * SEQ_BITS + TIME_BITS + 6 + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // seq_num, sent_time, now_time
   input  logic [IN_W-1:0]                   req_tdata,
   // kind
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // win_first, win_last, retransmit_wait, send_window, retransmit,
   // send_fin, send_ack, ignored, avoidance_mode
   output logic [OUT_W-1:0]                  rsp_tdata,
   input  logic                              csr_we,
   input  logic [tcpt_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [tcpt_pkg::CFG_BITS-1:0]     csr_wdata
);

   localparam int SB = SEQ_BITS;
   localparam int TB = TIME_BITS;
   localparam int GB = tcpt_pkg::GAIN_BITS;
   localparam int FB = tcpt_pkg::FRAC_BITS;
   localparam int KB = tcpt_pkg::CFG_BITS;
   localparam int NW = (SB > KB) ? SB : KB;
   localparam int PW = NW + 2;
   localparam int MW0 = (TB > SB + 1) ? TB : SB + 1;
   localparam int MW = (MW0 > GB) ? MW0 : GB;
   localparam int AW = MW + GB + 1;
   localparam int WW = TB + 3;

   // configuration
   logic [KB-1:0] total_packets_ff, initial_window_ff, rtt_gain_ff, wait_offset_ff;

   // flow state
   tcpt_pkg::stage_type stage_ff, stage_in;
   logic          avoid_ff, avoid_in;
   logic [SB-1:0] low_ff, low_in, high_ff, high_in;
   logic [SB:0]   ssth_ff, ssth_in;
   logic [2:0]    dup_ff, dup_in;
   logic [FB-1:0] frac_ff, frac_in;
   logic [TB-1:0] last_to_ff, last_to_in;
   logic [TB-1:0] avg_ff, dev_ff, wait_ff;

   // sequencer and working registers
   tcpt_pkg::fsm_type state_ff, state_in;
   logic              issued_ff, issued_in;
   tcpt_pkg::kind_type kind_ff;
   logic [SB-1:0]     seq_ff;
   logic [TB-1:0]     sent_ff, now_ff, rtt_ff, tmp_ff, diff_ff;
   logic [GB-1:0]     quo_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_data_ff, rsp_data_in;

   // shared unit
   tcpt_pkg::unit_ctl_type unit_ctl;
   tcpt_pkg::unit_sts_type unit_sts;
   logic [MW-1:0]  unit_mcand;
   logic [GB-1:0]  unit_mplier;
   logic [AW-1:0]  unit_product;
   logic [GB-1:0]  unit_quotient;
   logic [TB-1:0]  prod_hi;

   logic          req_fire, finish_fire;
   logic [TB-1:0] rtt_c;
   logic [SB:0]   size_c;
   logic [GB-1:0] keep_c;
   logic [PW-1:0] seq_x, tot_x;
   logic          ack_ok, ack_fin, to_ok, dup4, dup_fire, need_div;
   logic [2:0]    dup_next;
   logic [WW-1:0] wait_sum;

   logic          f_send, f_retx, f_fin, f_ack, f_ign;
   logic [PW-1:0] grow_size, grow_end, grow_cap;
   logic [FB+1:0] frac_sum;
   logic [NW-1:0] iw_eff, first_win;

   assign req_tready = (state_ff == tcpt_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- derived terms of the current request ----------------
   assign rtt_c   = (now_ff >= sent_ff) ? (now_ff - sent_ff) : '0;
   assign size_c  = {1'b0, high_ff} - {1'b0, low_ff} + 1'b1;
   assign keep_c  = tcpt_pkg::GAIN_ONE - {1'b0, rtt_gain_ff};
   assign seq_x   = PW'(seq_ff);
   assign tot_x   = PW'(total_packets_ff);
   assign prod_hi = unit_product[FB +: TB];

   assign ack_ok  = (stage_ff == tcpt_pkg::STAGE_DATA) && (seq_ff >= low_ff) &&
                    (sent_ff >= last_to_ff) && (seq_x <= tot_x);
   assign ack_fin = (seq_x == tot_x);
   assign to_ok   = (stage_ff == tcpt_pkg::STAGE_DATA) && (sent_ff >= last_to_ff) &&
                    (seq_ff >= low_ff) && (seq_ff <= high_ff);
   assign dup_next = (seq_ff == low_ff) ? (dup_ff + 3'd1) : 3'd0;
   assign dup4     = (dup_next > 3'd3);
   // the duplicate-driven timeout passes now_time as the send time
   assign dup_fire = (now_ff >= last_to_ff);
   assign need_div = !ack_fin && avoid_ff && !dup4;

   // wait = A + A/2 + 4D + offset, held at all ones on overflow
   assign wait_sum = WW'(avg_ff) + WW'(avg_ff >> 1) + (WW'(dev_ff) << 2) +
                     WW'(wait_offset_ff);

   // ---------------- operand selection for the shared unit ----------------
   always_comb begin
      unit_mcand  = MW'(avg_ff);
      unit_mplier = keep_c;
      unique case (state_ff)
         tcpt_pkg::ST_MUL_RG: begin
            unit_mcand  = MW'(rtt_ff);
            unit_mplier = {1'b0, rtt_gain_ff};
         end
         tcpt_pkg::ST_MUL_DK: begin
            unit_mcand  = MW'(dev_ff);
            unit_mplier = keep_c;
         end
         tcpt_pkg::ST_MUL_EG: begin
            unit_mcand  = MW'(diff_ff);
            unit_mplier = {1'b0, rtt_gain_ff};
         end
         tcpt_pkg::ST_DIV: begin
            unit_mcand  = MW'(size_c);
            unit_mplier = tcpt_pkg::GAIN_ONE;
         end
         default: begin
            unit_mcand  = MW'(avg_ff);
            unit_mplier = keep_c;
         end
      endcase
   end

   tcpt_mac_unit #(.MW(MW)) u_unit (
      .clock    (clock),
      .reset    (reset),
      .ctl      (unit_ctl),
      .mcand    (unit_mcand),
      .mplier   (unit_mplier),
      .sts      (unit_sts),
      .product  (unit_product),
      .quotient (unit_quotient)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in       = state_ff;
      issued_in      = issued_ff;
      unit_ctl.start = 1'b0;
      unit_ctl.op    = tcpt_pkg::OP_MUL;
      finish_fire    = 1'b0;
      unique case (state_ff)
         tcpt_pkg::ST_IDLE: begin
            if (req_fire) state_in = tcpt_pkg::ST_CHECK;
         end
         tcpt_pkg::ST_CHECK: begin
            priority if (kind_ff == tcpt_pkg::KIND_ACK && ack_ok)
               state_in = tcpt_pkg::ST_MUL_AK;
            else if (kind_ff == tcpt_pkg::KIND_SYNACK &&
                     stage_ff == tcpt_pkg::STAGE_HANDSHAKE)
               state_in = tcpt_pkg::ST_WAIT;
            else
               state_in = tcpt_pkg::ST_FINISH;
         end
         tcpt_pkg::ST_MUL_AK, tcpt_pkg::ST_MUL_RG,
         tcpt_pkg::ST_MUL_DK, tcpt_pkg::ST_MUL_EG, tcpt_pkg::ST_DIV: begin
            unit_ctl.op = (state_ff == tcpt_pkg::ST_DIV) ? tcpt_pkg::OP_DIV
                                                         : tcpt_pkg::OP_MUL;
            if (!issued_ff) begin
               unit_ctl.start = 1'b1;
               issued_in      = 1'b1;
            end else if (unit_sts.done) begin
               issued_in = 1'b0;
               unique case (state_ff)
                  tcpt_pkg::ST_MUL_AK: state_in = tcpt_pkg::ST_MUL_RG;
                  tcpt_pkg::ST_MUL_RG: state_in = tcpt_pkg::ST_MUL_DK;
                  tcpt_pkg::ST_MUL_DK: state_in = tcpt_pkg::ST_MUL_EG;
                  tcpt_pkg::ST_MUL_EG: state_in = tcpt_pkg::ST_WAIT;
                  default:             state_in = tcpt_pkg::ST_FINISH;
               endcase
            end
         end
         tcpt_pkg::ST_WAIT: begin
            state_in = (kind_ff == tcpt_pkg::KIND_ACK && need_div) ? tcpt_pkg::ST_DIV
                                                                   : tcpt_pkg::ST_FINISH;
         end
         tcpt_pkg::ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               finish_fire = 1'b1;
               state_in    = tcpt_pkg::ST_IDLE;
            end
         end
         default: state_in = tcpt_pkg::ST_IDLE;
      endcase
   end

   // ---------------- window update at the finish step ----------------
   always_comb begin
      stage_in   = stage_ff;
      avoid_in   = avoid_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      ssth_in    = ssth_ff;
      dup_in     = dup_ff;
      frac_in    = frac_ff;
      last_to_in = last_to_ff;
      f_send = 1'b0; f_retx = 1'b0; f_fin = 1'b0; f_ack = 1'b0; f_ign = 1'b0;

      frac_sum  = (FB+2)'(frac_ff) + (FB+2)'(quo_ff);
      grow_size = avoid_ff ? (PW'(size_c) + PW'(frac_sum[FB+1:FB]))
                           : (PW'(size_c) + 1'b1);
      grow_end  = seq_x + grow_size - 1'b1;
      grow_cap  = tot_x - 1'b1;
      iw_eff    = (initial_window_ff == '0) ? NW'(1) : NW'(initial_window_ff);
      first_win = (iw_eff < NW'(total_packets_ff)) ? iw_eff : NW'(total_packets_ff);

      unique case (kind_ff)
         tcpt_pkg::KIND_SYNACK: begin
            if (stage_ff != tcpt_pkg::STAGE_HANDSHAKE) begin
               f_ign = 1'b1;
            end else begin
               stage_in = tcpt_pkg::STAGE_DATA;
               low_in   = '0;
               high_in  = (total_packets_ff == '0) ? '0 : SB'(first_win - 1'b1);
               f_ack    = 1'b1;
               f_send   = 1'b1;
            end
         end
         tcpt_pkg::KIND_TIMEOUT: begin
            if (to_ok) begin
               last_to_in = now_ff;
               avoid_in   = 1'b0;
               ssth_in    = size_c >> 1;
               high_in    = low_ff;
               f_retx     = 1'b1;
            end else begin
               f_ign = 1'b1;
            end
         end
         tcpt_pkg::KIND_ACK: begin
            priority if (!ack_ok) begin
               f_ign = 1'b1;
            end else if (ack_fin) begin
               low_in   = seq_ff;
               high_in  = seq_ff;
               stage_in = tcpt_pkg::STAGE_DONE;
               f_fin    = 1'b1;
            end else if (avoid_ff && dup4) begin
               // fourth duplicate: drop to one packet as a timeout would
               dup_in = '0;
               if (dup_fire) begin
                  last_to_in = now_ff;
                  avoid_in   = 1'b0;
                  ssth_in    = size_c >> 1;
                  high_in    = low_ff;
                  f_retx     = 1'b1;
               end
            end else begin
               if (avoid_ff) begin
                  dup_in  = dup_next;
                  frac_in = frac_sum[FB-1:0];
               end else if (grow_size > PW'(ssth_ff)) begin
                  avoid_in = 1'b1;
               end
               low_in  = seq_ff;
               high_in = SB'((grow_end > grow_cap) ? grow_cap : grow_end);
               f_send  = 1'b1;
            end
         end
         default: f_ign = 1'b1;
      endcase

      rsp_valid_in = finish_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = OUT_W'({avoid_in, f_ign, f_ack, f_fin, f_retx, f_send,
                             wait_ff, high_in, low_in});
   end

   // ---------------- registers with reset ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= tcpt_pkg::ST_IDLE;
         issued_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         total_packets_ff  <= tcpt_pkg::RST_TOTAL_PACKETS;
         initial_window_ff <= tcpt_pkg::RST_INITIAL_WINDOW;
         rtt_gain_ff       <= tcpt_pkg::RST_RTT_GAIN;
         wait_offset_ff    <= tcpt_pkg::RST_WAIT_OFFSET;
         stage_ff          <= tcpt_pkg::STAGE_HANDSHAKE;
         avoid_ff          <= 1'b0;
         low_ff            <= '0;
         high_ff           <= '0;
         ssth_ff           <= '1;
         dup_ff            <= '0;
         frac_ff           <= '0;
         last_to_ff        <= '0;
         avg_ff            <= '0;
         dev_ff            <= '0;
         wait_ff           <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (tcpt_pkg::csr_index_type'(csr_index))
               tcpt_pkg::CSR_TOTAL_PACKETS:  total_packets_ff  <= csr_wdata;
               tcpt_pkg::CSR_INITIAL_WINDOW: initial_window_ff <= csr_wdata;
               tcpt_pkg::CSR_RTT_GAIN:       rtt_gain_ff       <= csr_wdata;
               tcpt_pkg::CSR_WAIT_OFFSET:    wait_offset_ff    <= csr_wdata;
               default: ;
            endcase
         end
         // the synack seeds both averages with its round trip
         if (state_ff == tcpt_pkg::ST_CHECK && kind_ff == tcpt_pkg::KIND_SYNACK &&
             stage_ff == tcpt_pkg::STAGE_HANDSHAKE) begin
            avg_ff <= rtt_c;
            dev_ff <= rtt_c;
         end
         if (issued_ff && unit_sts.done) begin
            if (state_ff == tcpt_pkg::ST_MUL_RG) avg_ff <= tmp_ff + prod_hi;
            if (state_ff == tcpt_pkg::ST_MUL_EG) dev_ff <= tmp_ff + prod_hi;
         end
         if (state_ff == tcpt_pkg::ST_WAIT)
            wait_ff <= (wait_sum[WW-1:TB] != '0) ? '1 : wait_sum[TB-1:0];
         if (finish_fire) begin
            stage_ff   <= stage_in;
            avoid_ff   <= avoid_in;
            low_ff     <= low_in;
            high_ff    <= high_in;
            ssth_ff    <= ssth_in;
            dup_ff     <= dup_in;
            frac_ff    <= frac_in;
            last_to_ff <= last_to_in;
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= tcpt_pkg::kind_type'(req_tuser);
         seq_ff  <= req_tdata[SB-1:0];
         sent_ff <= req_tdata[SB +: TB];
         now_ff  <= req_tdata[SB+TB +: TB];
      end
      if (state_ff == tcpt_pkg::ST_CHECK) rtt_ff <= rtt_c;
      if (issued_ff && unit_sts.done) begin
         if (state_ff == tcpt_pkg::ST_MUL_AK || state_ff == tcpt_pkg::ST_MUL_DK)
            tmp_ff <= prod_hi;
         if (state_ff == tcpt_pkg::ST_MUL_DK)
            diff_ff <= (rtt_ff >= avg_ff) ? (rtt_ff - avg_ff) : (avg_ff - rtt_ff);
         if (state_ff == tcpt_pkg::ST_DIV)
            quo_ff <= unit_quotient;
      end
      if (finish_fire) rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/tcpt_checker.sv =====
// Port-level checks for the TCP Tahoe window controller, bound to the top.
// Depends on tcpt_pkg, and on tcp_tahoe_window_control for its port shape.
module tcpt_checker #(
   parameter int SEQ_BITS  = tcpt_pkg::SEQ_BITS_DEF,
   parameter int TIME_BITS = tcpt_pkg::TIME_BITS_DEF,
   localparam int OUT_W = ((2 * SEQ_BITS + TIME_BITS + 6 + 7) / 8) * 8,
   localparam int FLAG0 = 2 * SEQ_BITS + TIME_BITS
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [OUT_W-1:0] rsp_tdata
);

   logic [5:0] flags;
   assign flags = rsp_tdata[FLAG0 +: 6];

   // hold a result until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

   // one request at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is at work");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an ignored request raises no other action
   a_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && flags[4] |-> (flags[3:0] == 4'b0000))
      else $error("ignored request carries an action flag");

endmodule

bind tcp_tahoe_window_control tcpt_checker #(
   .SEQ_BITS  (SEQ_BITS),
   .TIME_BITS (TIME_BITS)
) u_tcpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
